>>> hw/rtl/sod_pkg.sv
// Shared constants for the order-preserving duplicate filter.
package sod_pkg;

    // Width of one stream element
    localparam int unsigned SOD_VALUE_W  = 32;
    // Default number of distinct values the seen set can record
    localparam int unsigned SOD_CAPACITY = 64;

endpackage : sod_pkg

>>> hw/rtl/sod_if.sv
// Stream channel interfaces: element requests in, filtered results out.
interface sod_in_if;
    import sod_pkg::*;

    logic                          valid;
    logic                          ready;
    logic signed [SOD_VALUE_W-1:0] value;
    logic                          end_of_sequence;

    modport source (output valid, output value, output end_of_sequence, input ready);
    modport sink   (input valid, input value, input end_of_sequence, output ready);
endinterface : sod_in_if

interface sod_out_if;
    import sod_pkg::*;

    logic                          valid;
    logic                          ready;
    logic signed [SOD_VALUE_W-1:0] value_out;
    logic                          keep;
    logic                          end_out;
    logic                          set_overflow;

    modport source (output valid, output value_out, output keep, output end_out,
                    output set_overflow, input ready);
    modport sink   (input valid, input value_out, input keep, input end_out,
                    input set_overflow, output ready);
endinterface : sod_out_if

>>> hw/rtl/sod_mem.sv
// Simple dual-port memory holding the recorded values, registered read.
module sod_mem
    import sod_pkg::*;
#(
    parameter int unsigned DEPTH  = SOD_CAPACITY,
    parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
    input  logic                   i_clk,
    input  logic                   i_we,
    input  logic [ADDR_W-1:0]      i_waddr,
    input  logic [SOD_VALUE_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0]      i_raddr,
    output logic [SOD_VALUE_W-1:0] o_rdata
);

    logic [SOD_VALUE_W-1:0] r_mem [DEPTH];
    logic [SOD_VALUE_W-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, registered (old data on a same-address write)
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule : sod_mem

>>> hw/rtl/sod_ctrl.sv
// Sequencer: scans the seen set for each element, records new values, drives results.
module sod_ctrl
    import sod_pkg::*;
#(
    parameter int unsigned CAPACITY = SOD_CAPACITY,
    parameter int unsigned ADDR_W   = $clog2(CAPACITY),
    parameter int unsigned CNT_W    = $clog2(CAPACITY + 1)
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    sod_in_if.sink                 i_in,
    sod_out_if.source              o_out,
    output logic                   o_mem_we,
    output logic [ADDR_W-1:0]      o_mem_waddr,
    output logic [SOD_VALUE_W-1:0] o_mem_wdata,
    output logic [ADDR_W-1:0]      o_mem_raddr,
    input  logic [SOD_VALUE_W-1:0] i_mem_rdata
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } t_state;

    t_state                 r_state, n_state;
    logic [SOD_VALUE_W-1:0] r_val, n_val;
    logic                   r_end, n_end;
    logic                   r_hit, n_hit;
    logic [ADDR_W-1:0]      r_idx, n_idx;
    logic [CNT_W-1:0]       r_count, n_count;

    logic                   r_out_valid, n_out_valid;
    logic [SOD_VALUE_W-1:0] r_out_value, n_out_value;
    logic                   r_out_keep, n_out_keep;
    logic                   r_out_end, n_out_end;
    logic                   r_out_ovf, n_out_ovf;

    logic                   out_free;
    logic                   set_full;
    logic                   last_entry;

    assign out_free   = !r_out_valid || o_out.ready;
    assign set_full   = (r_count == CNT_W'(CAPACITY));
    assign last_entry = ((CNT_W'(r_idx) + CNT_W'(1)) == r_count);

    // Next-state logic
    always_comb begin
        n_state     = r_state;
        n_val       = r_val;
        n_end       = r_end;
        n_hit       = r_hit;
        n_idx       = r_idx;
        n_count     = r_count;
        n_out_valid = r_out_valid;
        n_out_value = r_out_value;
        n_out_keep  = r_out_keep;
        n_out_end   = r_out_end;
        n_out_ovf   = r_out_ovf;
        o_mem_we    = 1'b0;
        o_mem_waddr = r_count[ADDR_W-1:0];
        o_mem_wdata = r_val;
        o_mem_raddr = '0;

        // result taken by the receiver
        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                // entry 0 is read at the accept edge
                if (i_in.valid) begin
                    n_val   = i_in.value;
                    n_end   = i_in.end_of_sequence;
                    n_idx   = '0;
                    n_hit   = 1'b0;
                    n_state = (r_count == '0) ? ST_DONE : ST_SCAN;
                end
            end
            ST_SCAN: begin
                // read data belongs to entry r_idx
                if (i_mem_rdata == r_val) begin
                    n_hit   = 1'b1;
                    n_state = ST_DONE;
                end else if (last_entry) begin
                    n_state = ST_DONE;
                end else begin
                    n_idx       = r_idx + ADDR_W'(1);
                    o_mem_raddr = n_idx;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_value = r_val;
                    n_out_keep  = !r_hit;
                    n_out_end   = r_end;
                    n_out_ovf   = !r_hit && set_full;
                    // record a new value while room is left
                    if (!r_hit && !set_full) begin
                        o_mem_we = 1'b1;
                        n_count  = r_count + CNT_W'(1);
                    end
                    // end of sequence empties the set
                    if (r_end) begin
                        n_count = '0;
                    end
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_val       <= n_val;
        r_end       <= n_end;
        r_hit       <= n_hit;
        r_idx       <= n_idx;
        r_out_value <= n_out_value;
        r_out_keep  <= n_out_keep;
        r_out_end   <= n_out_end;
        r_out_ovf   <= n_out_ovf;
    end

    assign i_in.ready         = (r_state == ST_IDLE);
    assign o_out.valid        = r_out_valid;
    assign o_out.value_out    = r_out_value;
    assign o_out.keep         = r_out_keep;
    assign o_out.end_out      = r_out_end;
    assign o_out.set_overflow = r_out_ovf;

endmodule : sod_ctrl

>>> hw/rtl/stream_order_preserving_dedup.sv
// Top level of the order-preserving duplicate filter.
//
// Usage:
//   i_in carries one signed 32-bit element per request plus an end-of-sequence
//   flag. o_out returns exactly one result per element, in order: the value,
//   keep (first occurrence in the current sequence), the end flag, and
//   set_overflow (new value seen while the set already holds CAPACITY values;
//   such a value is passed with keep set but not recorded).
//   Distinct values are stored in a single memory and searched through its
//   one read port, one entry per cycle, from the oldest entry on.
//   An element is compared against entries until a match or until every entry
//   within the current fill count is compared; its result is then registered
//   once the output register is free. The next element is accepted the cycle
//   after a result is registered.
//   After the element flagged end_of_sequence the fill count drops to zero,
//   which empties the set at once.
//   Reset clears the fill count and the result register; memory contents are
//   not cleared and need no clearing pass.
//   When the receiver stalls, the result holds in the output register; one
//   more element is accepted and searched, then the block waits.
module stream_order_preserving_dedup
    import sod_pkg::*;
#(
    parameter int unsigned CAPACITY = SOD_CAPACITY
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sod_in_if.sink    i_in,
    sod_out_if.source o_out
);

    localparam int unsigned ADDR_W = $clog2(CAPACITY);
    localparam int unsigned CNT_W  = $clog2(CAPACITY + 1);

    logic                   mem_we;
    logic [ADDR_W-1:0]      mem_waddr;
    logic [SOD_VALUE_W-1:0] mem_wdata;
    logic [ADDR_W-1:0]      mem_raddr;
    logic [SOD_VALUE_W-1:0] mem_rdata;

    // Search sequencer and result register
    sod_ctrl #(
        .CAPACITY (CAPACITY),
        .ADDR_W   (ADDR_W),
        .CNT_W    (CNT_W)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_out       (o_out),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata)
    );

    // Seen-value store
    sod_mem #(
        .DEPTH  (CAPACITY),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

endmodule : stream_order_preserving_dedup

>>> hw/rtl/sod_checker.sv
// Port-level checker for the duplicate filter, bound to the top level.
module sod_checker
    import sod_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_in_valid,
    input logic                   i_in_ready,
    input logic                   i_out_valid,
    input logic                   i_out_ready,
    input logic [SOD_VALUE_W-1:0] i_out_value,
    input logic                   i_out_keep,
    input logic                   i_out_end,
    input logic                   i_out_ovf
);

    logic       in_acc;
    logic       out_acc;
    logic [1:0] r_pend;

    assign in_acc  = i_in_valid && i_in_ready;
    assign out_acc = i_out_valid && i_out_ready;

    // Requests accepted but not yet answered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else begin
            r_pend <= r_pend + {1'b0, in_acc} - {1'b0, out_acc};
        end
    end

    // A stalled result stays valid
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
        $stable(i_out_value) && $stable(i_out_keep) && $stable(i_out_end)
        && $stable(i_out_ovf))
        else $error("result payload changed while stalled");

    // Overflow only on a kept value
    a_ovf_keep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !(i_out_ovf && !i_out_keep))
        else $error("overflow flagged on a duplicate");

    // Every result answers an earlier request, and at most two are in flight
    a_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid |-> r_pend != 2'd0) and (r_pend != 2'd3))
        else $error("result count does not track requests");

endmodule : sod_checker

bind stream_order_preserving_dedup sod_checker u_sod_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_value (o_out.value_out),
    .i_out_keep  (o_out.keep),
    .i_out_end   (o_out.end_out),
    .i_out_ovf   (o_out.set_overflow)
);
